// ===== design/merge_insertion_sorter_macros.svh =====
// Assertion macros for the merge insertion sorter.
`ifndef MERGE_INSERTION_SORTER_MACROS_SVH
`define MERGE_INSERTION_SORTER_MACROS_SVH

`ifndef SYNTHESIS
`define MSORT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("merge_insertion_sorter: assertion failed");
`define MSORT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("merge_insertion_sorter: assertion failed");
`else
`define MSORT_ASSERT(label, prop)
`define MSORT_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/msort_pkg.sv =====
// Shared constants and types for the merge insertion sorter.
package msort_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned VAL_W        = 31;
  localparam int unsigned TDATA_W      = 32;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== design/merge_insertion_sorter.sv =====
// Top level of the merge insertion sorter: a chain of sorting cells with a fill/drain controller.
//
// Input channel (s_axis_*): one value per transaction, tlast marks the final value of a run.
// The value is inserted into a chain of CAPACITY cells kept in ascending order; each cell
// compares the new value with its own and either keeps it, takes the new value, or takes
// its left neighbour's value, and one input transaction is taken every cycle while a run
// is being collected.
// Values arriving once all CAPACITY cells are occupied are dropped, and every result of
// that run then carries the overflow flag in tuser.
// After the transaction carrying tlast, the input stalls (s_axis_tready low) and the chain
// drains from cell 0: one result per cycle while the receiver is ready, the whole chain
// shifting left by one cell on each accepted output transaction. The largest value is
// marked with m_axis_tlast. The first result is offered in the cycle after the tlast
// transaction, and the drain is paced by the single output port at the head of the chain.
// If the receiver stalls, the head value simply stays on m_axis_tdata and the chain holds.
// Once the final result is taken, the count and the overflow flag clear and the input
// channel reopens. Reset empties the chain, clears the flag and opens the input channel.
module merge_insertion_sorter #(
  parameter int unsigned CAPACITY = msort_pkg::DEF_CAPACITY
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [msort_pkg::TDATA_W-1:0]  s_axis_tdata,  // [30:0] value, [31] zero
  input  logic                           s_axis_tlast,  // last
  // Output channel.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [msort_pkg::TDATA_W-1:0]  m_axis_tdata,  // [30:0] sorted_value, [31] zero
  output logic                           m_axis_tlast,  // final_res
  output logic                           m_axis_tuser   // [0] overflow
);
  import msort_pkg::*;

`include "merge_insertion_sorter_macros.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;

  logic             in_fire, out_fire, full;
  logic [VAL_W-1:0] in_val;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] cell_val  [CAPACITY];
  logic             cell_take [CAPACITY];

  assign in_val   = s_axis_tdata[VAL_W-1:0];
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.drain  = out_fire;

  // The chain of cells; cell 0 holds the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_take;
    logic [VAL_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_take = 1'b0;
      assign prev_val  = in_val;
    end else begin : g_body
      assign prev_take = cell_take[i-1];
      assign prev_val  = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    msort_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .in_val_i    (in_val),
      .occupied_i  (CNT_W'(i) < count_q),
      .prev_take_i (prev_take),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .take_o      (cell_take[i]),
      .val_o       (cell_val[i])
    );
  end

  // Fill/drain control.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_FILL: begin
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (s_axis_tlast) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_FILL;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign s_axis_tready = (state_q == ST_FILL);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign m_axis_tdata  = {{(TDATA_W - VAL_W){1'b0}}, cell_val[0]};
  assign m_axis_tlast  = (count_q == CNT_W'(1));
  assign m_axis_tuser  = ovf_q;

  // A drain never runs on an empty chain.
  `MSORT_ASSERT(a_drain_nonempty, (state_q == ST_DRAIN) |-> (count_q != '0))
  // Out of reset, the occupancy never exceeds the number of cells.
  `MSORT_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= CNT_W'(CAPACITY)))
  // Taking the final result empties the chain and clears the overflow flag.
  `MSORT_ASSERT(a_run_end, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
                (state_q == ST_FILL && count_q == '0 && !ovf_q))
  // The marked transaction always ends the run, even on a full chain.
  `MSORT_ASSERT(a_full_last, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
                (state_q == ST_DRAIN))

endmodule

// ===== design/msort_cell.sv =====
// One cell of the sorting chain: holds a single value and trades it with its neighbours.
module msort_cell (
  input  logic                           clk_i,
  input  msort_pkg::cell_ctrl_t          ctrl_i,
  input  logic [msort_pkg::VAL_W-1:0]    in_val_i,
  input  logic                           occupied_i,
  input  logic                           prev_take_i,
  input  logic [msort_pkg::VAL_W-1:0]    prev_val_i,
  input  logic [msort_pkg::VAL_W-1:0]    next_val_i,
  output logic                           take_o,
  output logic [msort_pkg::VAL_W-1:0]    val_o
);
  import msort_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;

  // An empty cell counts as larger than anything.
  assign take_o = !occupied_i || (in_val_i < val_q);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert && take_o) begin
      val_d = prev_take_i ? prev_val_i : in_val_i;
    end else if (ctrl_i.drain) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== sim/merge_insertion_sorter_tb.sv =====
// Self-checking testbench for the merge insertion sorter.
module merge_insertion_sorter_tb;

  localparam int unsigned CAP         = msort_pkg::DEF_CAPACITY;
  localparam int unsigned VW          = msort_pkg::VAL_W;
  localparam int          MAX_SHOWN   = 10;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RANDOM_ITEMS = 170;
  localparam int          DIRECTED_ITEMS = 17;

  typedef logic [VW-1:0] value_t;

  typedef struct {
    value_t value;
    bit     final_flag;
    bit     ovf;
  } sorted_result_t;

  // Keeps the values of the current run in ascending order and queues the sorted
  // output that the run's tlast transaction releases.
  class sort_scoreboard;
    value_t         run_values[$];
    bit             run_dropped;
    sorted_result_t sorted_queue[$];
    int             errors;

    function void note_input(value_t v, bit last_flag);
      int pos;
      sorted_result_t res;
      if (run_values.size() < CAP) begin
        pos = run_values.size();
        while (pos > 0 && run_values[pos-1] > v) pos--;
        run_values.insert(pos, v);
      end else begin
        run_dropped = 1'b1;
      end
      if (last_flag) begin
        foreach (run_values[k]) begin
          res = '{run_values[k], k == run_values.size() - 1, run_dropped};
          sorted_queue.insert(sorted_queue.size(), res);
        end
        run_values.delete();
        run_dropped = 1'b0;
      end
    endfunction

    function void check_result(value_t v, bit final_flag, bit ovf);
      sorted_result_t exp_res;
      if (sorted_queue.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result: value %h last %b overflow %b", v, final_flag, ovf);
        return;
      end
      exp_res = sorted_queue.pop_front();
      if (v !== exp_res.value || final_flag !== exp_res.final_flag || ovf !== exp_res.ovf) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: expected value %h last %b overflow %b, got %h %b %b",
                   exp_res.value, exp_res.final_flag, exp_res.ovf, v, final_flag, ovf);
      end
    endfunction

    function int pending();
      return sorted_queue.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  logic rx_ready = 1'b0;
  logic rx_hold  = 1'b0;
  bit   hold_go  = 1'b0;
  bit   tx_idle_on = 1'b1;
  int   cycles   = 0;

  sort_scoreboard sb = new();

  // The receiver's own readiness is masked by the long hold-off.
  assign m_axis_tready = rx_ready & ~rx_hold;

  merge_insertion_sorter #(.CAPACITY(CAP)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [30:0] value, [31] zero
    .s_axis_tlast  (s_axis_tlast),   // last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [30:0] sorted_value, [31] zero
    .m_axis_tlast  (m_axis_tlast),   // final_res
    .m_axis_tuser  (m_axis_tuser)    // [0] overflow
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Every output transaction is checked against the oldest queued result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[VW-1:0], m_axis_tlast, m_axis_tuser);
  end

  // Receiver: random stalls per result, with stretches of continuous readiness.
  initial begin
    int gap;
    int taken;
    bit idle_on;
    taken = 0;
    idle_on = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 16 == 0) idle_on = $urandom_range(0, 2) != 0;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rx_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
      @(negedge clk_i);
    end
  end

  // Long hold-off on the output, so that the sender runs into a stalled input.
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // Offers one value and waits for its transaction; entered and left at a falling edge.
  task automatic send_value(input value_t v, input bit last_flag);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v};
    s_axis_tlast  <= last_flag;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(v, last_flag);
    @(negedge clk_i);
  endtask

  // Mostly full-width random values, with extremes and a narrow range for duplicates.
  function automatic value_t random_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return value_t'($urandom_range(0, 7));
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic send_random_run(input int len);
    for (int i = 0; i < len; i++) send_value(random_value(), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed runs: single-value runs at both extremes, duplicates with both
    // extremes inside one run, an ascending and a descending run.
    send_value('0, 1'b1);
    send_value('1, 1'b1);
    send_value(value_t'(5), 1'b0);
    send_value(value_t'(3), 1'b0);
    send_value('1, 1'b0);
    send_value('0, 1'b0);
    send_value(value_t'(3), 1'b0);
    send_value(value_t'(5), 1'b0);
    send_value(value_t'(1), 1'b0);
    send_value(value_t'(31'h7FFF_FFFE), 1'b1);
    send_value(value_t'(1), 1'b0);
    send_value(value_t'(2), 1'b0);
    send_value(value_t'(3), 1'b1);
    send_value(value_t'(31'h5555_5555), 1'b0);
    send_value(value_t'(31'h4000_0000), 1'b0);
    send_value(value_t'(31'h2AAA_AAAA), 1'b0);
    send_value(value_t'(31'h0000_0001), 1'b1);

    // A run that exactly fills the chain, sent back to back: no overflow.
    tx_idle_on = 1'b0;
    send_random_run(CAP);

    // An overflowing run whose tlast value is itself dropped. The output is held
    // off meanwhile, so the next run is offered while the input is stalled.
    hold_go = 1'b1;
    for (int i = 0; i < CAP + 6; i++) send_value(random_value(), i == CAP + 5);
    sent = DIRECTED_ITEMS + 2 * CAP + 6;

    // Random runs: mostly short, now and then long enough to overflow.
    while (sent < RANDOM_ITEMS) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 4, CAP + 8)
                                        : $urandom_range(1, 10);
      send_random_run(len);
      sent += len;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/msort_pkg.sv
design/msort_cell.sv
design/merge_insertion_sorter.sv
sim/merge_insertion_sorter_tb.sv
